// ===== src/wcs_pkg.sv =====
// Package for the weighted credit task scheduler.
// Holds request, status and result codes, the slot entry layout and the
// controller/datapath command and status structs. No dependencies.
package wcs_pkg;

   localparam logic [2:0] REQ_REGISTER = 3'd0;
   localparam logic [2:0] REQ_RELEASE  = 3'd1;
   localparam logic [2:0] REQ_SET_CNT  = 3'd2;
   localparam logic [2:0] REQ_CLR_CNT  = 3'd3;
   localparam logic [2:0] REQ_CONSUME  = 3'd4;
   localparam logic [2:0] REQ_TICK     = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_BADSLOT  = 3'd2;
   localparam logic [2:0] ST_WAIT     = 3'd3;
   localparam logic [2:0] ST_OFF      = 3'd4;

   // Which result the datapath latches in a given cycle.
   localparam logic [2:0] RES_NONE     = 3'd0;
   localparam logic [2:0] RES_OFF      = 3'd1;
   localparam logic [2:0] RES_NOTFOUND = 3'd2;
   localparam logic [2:0] RES_BADSLOT  = 3'd3;
   localparam logic [2:0] RES_HIT      = 3'd4;
   localparam logic [2:0] RES_IDX      = 3'd5;
   localparam logic [2:0] RES_TICK0    = 3'd6;
   localparam logic [2:0] RES_TICK1    = 3'd7;

   localparam logic CSR_BLOCK_ON   = 1'b0;
   localparam logic CSR_TASK_COUNT = 1'b1;

   localparam logic [12:0] CREDIT_MAX = 13'd8191;

   typedef struct packed {
      logic [31:0] tag;
      logic [2:0]  weight;
      logic [12:0] credits;
      logic        counting;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       walk_start;
      logic       walk_step;
      logic       sum;
      logic       refill;
      logic       rd_idx;
      logic       push;
      logic [2:0] set_res;
   } cmd_type;

   typedef struct packed {
      logic       blk_on;
      logic [2:0] kind;
      logic       bad_slot;
      logic       hit;
      logic       walk_end;
      logic       sum_nz;
      logic       out_free;
   } stat_type;

   // Levels 0..4 map to weight 0..4, 5..8 to 1..4, anything else to 0.
   function automatic logic [2:0] weight_of_level(input logic signed [7:0] lvl);
      logic [2:0] w;
      begin
         if (lvl < 0 || lvl > 8) begin
            w = 3'd0;
         end else if (lvl < 5) begin
            w = lvl[2:0];
         end else begin
            w = 3'(lvl - 8'sd4);
         end
         return w;
      end
   endfunction

endpackage

// ===== src/wcs_ifs.sv =====
// Handshake channel interfaces of the weighted credit task scheduler:
// request, response and configuration write. Depends on nothing.
interface wcs_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        req_type;
   logic [31:0]       task_tag;
   logic signed [7:0] level;
   logic              count_flag;
   logic [5:0]        slot_index;
   modport source(output valid, req_type, task_tag, level, count_flag, slot_index,
                  input ready);
   modport sink(input valid, req_type, task_tag, level, count_flag, slot_index,
                output ready);
endinterface

interface wcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  slot_out;
   logic [12:0] credits_left;
   logic        refilled;
   modport source(output valid, status, slot_out, credits_left, refilled, input ready);
   modport sink(input valid, status, slot_out, credits_left, refilled, output ready);
endinterface

interface wcs_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [6:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== src/weighted_credit_task_scheduler_top.sv =====
// Weighted credit task scheduler. Requests are handled one at a time, and
// the slot table lives in a single RAM with one read port, so the cost of a
// request is set by how many slots must be read, one per cycle, for n =
// min(task_count, MAX_SLOTS): a disabled block, a bad slot or an unknown
// request answer in 3 cycles; clear counting and consume take 5; register,
// release and set counting take up to n + 5; a tick takes about n + 5 when
// counting slots still hold credit and about 2n + 7 when it refills. A
// finished result waits in the controller for as long as the previous beat
// is still held on the response side. A new request is taken while the
// previous beat still waits on the response side. The table reads as all
// zero after reset with no clearing pass.
// Depends on wcs_pkg, wcs_ifs, wcs_ctrl and wcs_datapath.
module weighted_credit_task_scheduler_top #(
   parameter int MAX_SLOTS   = 64,
   parameter int CREDIT_UNIT = 1000
) (
   input logic      clock,
   input logic      reset,
   wcs_req_if.sink   req_ch,
   wcs_rsp_if.source rsp_ch,
   wcs_csr_if.sink   csr_ch
);
   import wcs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ch.ready = 1'b1;

   wcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wcs_datapath #(.MAX_SLOTS(MAX_SLOTS), .CREDIT_UNIT(CREDIT_UNIT)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req_ch.req_type),
      .task_tag     (req_ch.task_tag),
      .level        (req_ch.level),
      .count_flag   (req_ch.count_flag),
      .slot_index   (req_ch.slot_index),
      .csr_valid    (csr_ch.valid),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .status       (rsp_ch.status),
      .slot_out     (rsp_ch.slot_out),
      .credits_left (rsp_ch.credits_left),
      .refilled     (rsp_ch.refilled)
   );
endmodule

// ===== src/wcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module wcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== src/wcs_datapath.sv =====
// Datapath of the weighted credit task scheduler: configuration registers,
// request latch, slot table RAM with valid bits, walk counter and result
// registers. Depends on wcs_pkg and wcs_ram.
module wcs_datapath #(
   parameter int MAX_SLOTS   = 64,
   parameter int CREDIT_UNIT = 1000
) (
   input  logic              clock,
   input  logic              reset,
   input  wcs_pkg::cmd_type  cmd,
   output wcs_pkg::stat_type stat,
   input  logic [2:0]        req_type,
   input  logic [31:0]       task_tag,
   input  logic signed [7:0] level,
   input  logic              count_flag,
   input  logic [5:0]        slot_index,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [6:0]        csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        status,
   output logic [5:0]        slot_out,
   output logic [12:0]       credits_left,
   output logic              refilled
);
   import wcs_pkg::*;

   localparam int AW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int NW = CW > 7 ? CW : 7;
   localparam int EW = $bits(entry_type);

   logic              block_on_ff;
   logic [6:0]        task_count_ff;
   logic [2:0]        req_type_ff;
   logic [31:0]       tag_ff;
   logic signed [7:0] level_ff;
   logic              flag_ff;
   logic [5:0]        idx_ff;
   logic [CW-1:0]     addr_ff, addr_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff;
   logic              sum_nz_ff, sum_nz_in;
   logic [MAX_SLOTS-1:0] valid_ff;

   logic [2:0]  res_status_ff, res_status_in;
   logic [5:0]  res_slot_ff, res_slot_in;
   logic [12:0] res_credits_ff, res_credits_in;
   logic        res_refill_ff, res_refill_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff;
   logic [5:0]  slot_out_ff;
   logic [12:0] credits_ff;
   logic        refilled_ff;

   logic [NW-1:0] n_eff;
   logic          addr_in_range;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] ram_q;
   entry_type     entry;
   logic [31:0]   search_tag;
   logic [15:0]   prod;
   logic [12:0]   refill_cr;
   logic          we;
   entry_type     wd;
   logic          out_free;

   assign n_eff = (NW'(task_count_ff) > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS)
                                                        : NW'(task_count_ff);
   assign addr_in_range = NW'(addr_ff) < n_eff;
   assign rd_addr = cmd.rd_idx ? AW'(idx_ff) : AW'(addr_ff);

   wcs_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (rd_idx_ff),
      .wdata (wd),
      .raddr (rd_addr),
      .rdata (ram_q)
   );

   // A slot never written since reset reads as all zero.
   assign entry = valid_ff[rd_idx_ff] ? entry_type'(ram_q) : '0;
   assign search_tag = (req_type_ff == REQ_REGISTER) ? 32'd0 : tag_ff;

   assign prod = (16'(entry.weight) + 16'd1) * 16'(CREDIT_UNIT);
   assign refill_cr = (prod > 16'(CREDIT_MAX)) ? CREDIT_MAX : prod[12:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.blk_on   = block_on_ff;
      stat.kind     = req_type_ff;
      stat.bad_slot = NW'(idx_ff) >= n_eff;
      stat.hit      = rd_vld_ff && (entry.tag == search_tag);
      stat.walk_end = !addr_in_range && !rd_vld_ff;
      stat.sum_nz   = sum_nz_ff;
      stat.out_free = out_free;
   end

   always_comb begin
      addr_in   = addr_ff;
      rd_vld_in = 1'b0;
      sum_nz_in = sum_nz_ff;
      if (cmd.walk_start) begin
         addr_in   = '0;
         sum_nz_in = 1'b0;
      end else if (cmd.walk_step && addr_in_range) begin
         addr_in   = addr_ff + CW'(1);
         rd_vld_in = 1'b1;
      end
      if (cmd.sum && rd_vld_ff && entry.counting && entry.credits != 13'd0) begin
         sum_nz_in = 1'b1;
      end
   end

   always_comb begin
      we = 1'b0;
      wd = entry;
      if (cmd.refill && rd_vld_ff && entry.tag != 32'd0) begin
         we         = 1'b1;
         wd.credits = refill_cr;
      end
      if (cmd.set_res == RES_HIT) begin
         we = 1'b1;
         case (req_type_ff)
            REQ_REGISTER: begin
               wd.tag     = tag_ff;
               wd.weight  = weight_of_level(level_ff);
               wd.credits = 13'd0;
            end
            REQ_RELEASE: begin
               wd.tag     = 32'd0;
               wd.credits = 13'd0;
            end
            default: begin
               wd.counting = flag_ff;
            end
         endcase
      end
      if (cmd.set_res == RES_IDX) begin
         if (req_type_ff == REQ_CLR_CNT) begin
            we          = 1'b1;
            wd.counting = 1'b0;
         end else if (entry.credits != 13'd0) begin
            we         = 1'b1;
            wd.credits = entry.credits - 13'd1;
         end
      end
   end

   always_comb begin
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_credits_in = res_credits_ff;
      res_refill_in  = res_refill_ff;
      if (cmd.set_res != RES_NONE) begin
         res_status_in  = ST_OK;
         res_slot_in    = 6'd0;
         res_credits_in = 13'd0;
         res_refill_in  = 1'b0;
      end
      case (cmd.set_res)
         RES_OFF:      res_status_in = ST_OFF;
         RES_NOTFOUND: res_status_in = ST_NOTFOUND;
         RES_BADSLOT:  res_status_in = ST_BADSLOT;
         RES_HIT: begin
            res_slot_in = 6'(rd_idx_ff);
            if (req_type_ff == REQ_SET_CNT) begin
               res_credits_in = entry.credits;
            end
         end
         RES_IDX: begin
            res_slot_in = 6'(rd_idx_ff);
            if (req_type_ff == REQ_CLR_CNT) begin
               res_credits_in = entry.credits;
            end else if (entry.credits == 13'd0) begin
               res_status_in = ST_WAIT;
            end else begin
               res_credits_in = entry.credits - 13'd1;
            end
         end
         RES_TICK1:    res_refill_in = 1'b1;
         default:      ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_on_ff   <= 1'b0;
         task_count_ff <= 7'd0;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         addr_ff       <= '0;
         sum_nz_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_BLOCK_ON) begin
               block_on_ff <= csr_data[0];
            end else begin
               task_count_ff <= csr_data;
            end
         end
         rd_vld_ff    <= rd_vld_in;
         addr_ff      <= addr_in;
         sum_nz_ff    <= sum_nz_in;
         rsp_valid_ff <= rsp_valid_in;
         if (we) begin
            valid_ff[rd_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_addr;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_credits_ff <= res_credits_in;
      res_refill_ff  <= res_refill_in;
      if (cmd.load) begin
         req_type_ff <= req_type;
         tag_ff      <= task_tag;
         level_ff    <= level;
         flag_ff     <= count_flag;
         idx_ff      <= slot_index;
      end
      if (cmd.push) begin
         status_ff   <= res_status_ff;
         slot_out_ff <= res_slot_ff;
         credits_ff  <= res_credits_ff;
         refilled_ff <= res_refill_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign status       = status_ff;
   assign slot_out     = slot_out_ff;
   assign credits_left = credits_ff;
   assign refilled     = refilled_ff;
endmodule

// ===== src/wcs_ctrl.sv =====
// Controller state machine of the weighted credit task scheduler: sequences
// slot walks, indexed accesses and result hand-off. Depends on wcs_pkg.
module wcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wcs_pkg::stat_type stat,
   output wcs_pkg::cmd_type  cmd
);
   import wcs_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_TICK2 = 3'd3;
   localparam logic [2:0] S_IDXRD = 3'd4;
   localparam logic [2:0] S_IDXOP = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!stat.blk_on) begin
               cmd.set_res = RES_OFF;
               state_in    = S_DONE;
            end else begin
               case (stat.kind)
                  REQ_REGISTER, REQ_RELEASE, REQ_SET_CNT, REQ_TICK: begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
                  REQ_CLR_CNT, REQ_CONSUME: begin
                     if (stat.bad_slot) begin
                        cmd.set_res = RES_BADSLOT;
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_IDXRD;
                     end
                  end
                  default: begin
                     cmd.set_res = RES_NOTFOUND;
                     state_in    = S_DONE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (stat.kind == REQ_TICK) begin
               // First pass only looks for any credit left in counting slots.
               cmd.sum = 1'b1;
               if (stat.walk_end) begin
                  if (stat.sum_nz) begin
                     cmd.set_res = RES_TICK0;
                     state_in    = S_DONE;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_TICK2;
                  end
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end else if (stat.hit) begin
               cmd.set_res = RES_HIT;
               state_in    = S_DONE;
            end else if (stat.walk_end) begin
               cmd.set_res = RES_NOTFOUND;
               state_in    = S_DONE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_TICK2: begin
            cmd.refill = 1'b1;
            if (stat.walk_end) begin
               cmd.set_res = RES_TICK1;
               state_in    = S_DONE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_IDXRD: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_IDXOP;
         end
         S_IDXOP: begin
            cmd.set_res = RES_IDX;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
